### rtl/core/slu_pkg.sv
package slu_pkg;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdFirst  = 2'd1,
    CmdSecond = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StsCleared   = 3'd0,
    StsAdded     = 3'd1,
    StsDuplicate = 3'd2,
    StsOrder     = 3'd3,
    StsFull      = 3'd4,
    StsPhase     = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic needs_scan;
    logic scan_last;
  } dp_sts_t;

endpackage

### rtl/core/sorted_list_union.sv
// Channel  Handshake                 Ports
// -------  ------------------------  ----------------------------------------
// input    start high, busy low      command_i, item_value_i
// result   done_o strobe, one cycle  union_value_o, status_o, union_size_o
//
// Clear, first-list and rejected items, and second-list items on an empty
// union, go from transfer to result through the Eval state. A second-list item
// checked against the store goes on through Scan and Finish; the scan reads
// each union entry in turn from the store's single read port, one per cycle.
// Reset is asynchronous and active low and empties the union; no clearing pass.
// Results cannot be stalled: each appears for one cycle while busy is low.
module sorted_list_union
  import slu_pkg::*;
#(
  parameter int LIST_DEPTH = 16,
  localparam int CntW = $clog2(2 * LIST_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic signed [31:0] union_value_o,
  output logic [2:0]         status_o,
  output logic [CntW-1:0]    union_size_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  slu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (dp_sts),
    .cmd_o  (ctrl_cmd)
  );

  slu_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .sts_o         (dp_sts),
    .command_i     (command_i),
    .item_value_i  (item_value_i),
    .done_o        (done_o),
    .union_value_o (union_value_o),
    .status_o      (status_o),
    .union_size_o  (union_size_o)
  );

endmodule

### rtl/core/slu_ctrl.sv
module slu_ctrl
  import slu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StEval   = 2'd1;
  localparam logic [1:0] StScan   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.latch  = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = StEval;
        end
      end
      StEval: begin
        if (sts_i.needs_scan) begin
          state_d = StScan;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      StScan: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

### rtl/core/slu_datapath.sv
module slu_datapath
  import slu_pkg::*;
#(
  parameter int LIST_DEPTH = 16,
  localparam int StoreDepth = 2 * LIST_DEPTH,
  localparam int CntW = $clog2(StoreDepth + 1),
  localparam int ListW = $clog2(LIST_DEPTH + 1),
  localparam int AddrW = $clog2(StoreDepth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_sts_t            sts_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic signed [31:0] union_value_o,
  output logic [2:0]         status_o,
  output logic [CntW-1:0]    union_size_o
);

  localparam logic [ListW-1:0] ListMax  = ListW'(LIST_DEPTH);
  localparam logic [CntW-1:0]  StoreMax = CntW'(StoreDepth);

  logic [31:0] store_mem [StoreDepth];

  logic [1:0]         cmd_q;
  logic signed [31:0] val_q;
  logic [AddrW-1:0]   addr_q;
  logic [31:0]        rd_q;
  logic               cmp_en_q;
  logic               found_q;

  logic [CntW-1:0]    union_cnt_q, union_cnt_d;
  logic [ListW-1:0]   first_cnt_q, first_cnt_d;
  logic [ListW-1:0]   second_cnt_q, second_cnt_d;
  logic signed [31:0] last_first_q, last_first_d;
  logic signed [31:0] last_second_q, last_second_d;

  logic               done_q;
  logic signed [31:0] out_val_q;
  logic [2:0]         out_sts_q;
  logic [CntW-1:0]    out_size_q;

  logic    match;
  logic    found_now;
  logic    second_ok;
  logic    store_wr;
  status_e status_d;

  assign match     = cmp_en_q && (rd_q == val_q);
  assign found_now = found_q || match;

  // A second-list item that passes the full and order checks.
  assign second_ok = (second_cnt_q != ListMax) && (union_cnt_q != StoreMax) &&
                     !((second_cnt_q != '0) && (val_q < last_second_q));

  assign sts_o.needs_scan = (cmd_q == CmdSecond) && second_ok && (union_cnt_q != '0);
  assign sts_o.scan_last  = (CntW'(addr_q) == (union_cnt_q - CntW'(1)));

  always_comb begin
    union_cnt_d   = union_cnt_q;
    first_cnt_d   = first_cnt_q;
    second_cnt_d  = second_cnt_q;
    last_first_d  = last_first_q;
    last_second_d = last_second_q;
    store_wr      = 1'b0;
    status_d      = StsPhase;
    unique case (cmd_q)
      CmdClear: begin
        union_cnt_d   = '0;
        first_cnt_d   = '0;
        second_cnt_d  = '0;
        last_first_d  = '0;
        last_second_d = '0;
        status_d      = StsCleared;
      end
      CmdFirst: begin
        if (second_cnt_q != '0) begin
          status_d = StsPhase;
        end else if ((first_cnt_q == ListMax) || (union_cnt_q == StoreMax)) begin
          status_d = StsFull;
        end else if ((first_cnt_q != '0) && (val_q < last_first_q)) begin
          status_d = StsOrder;
        end else begin
          store_wr     = 1'b1;
          union_cnt_d  = union_cnt_q + CntW'(1);
          first_cnt_d  = first_cnt_q + ListW'(1);
          last_first_d = val_q;
          status_d     = StsAdded;
        end
      end
      CmdSecond: begin
        if ((second_cnt_q == ListMax) || (union_cnt_q == StoreMax)) begin
          status_d = StsFull;
        end else if (!second_ok) begin
          status_d = StsOrder;
        end else begin
          second_cnt_d  = second_cnt_q + ListW'(1);
          last_second_d = val_q;
          if (found_now) begin
            status_d = StsDuplicate;
          end else begin
            store_wr    = 1'b1;
            union_cnt_d = union_cnt_q + CntW'(1);
            status_d    = StsAdded;
          end
        end
      end
      default: begin
        status_d = StsPhase;
      end
    endcase
  end

  // Union store: one write port, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && store_wr) begin
      store_mem[union_cnt_q[AddrW-1:0]] <= val_q;
    end
    if (cmd_i.issue) begin
      rd_q <= store_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= command_i;
      val_q <= item_value_i;
    end
    if (cmd_i.finish) begin
      out_val_q  <= val_q;
      out_sts_q  <= status_d;
      out_size_q <= union_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q        <= '0;
      cmp_en_q      <= 1'b0;
      found_q       <= 1'b0;
      done_q        <= 1'b0;
      union_cnt_q   <= '0;
      first_cnt_q   <= '0;
      second_cnt_q  <= '0;
      last_first_q  <= '0;
      last_second_q <= '0;
    end else begin
      cmp_en_q <= cmd_i.issue;
      done_q   <= cmd_i.finish;
      if (cmd_i.latch) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          addr_q <= addr_q + AddrW'(1);
        end
        if (match) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        union_cnt_q   <= union_cnt_d;
        first_cnt_q   <= first_cnt_d;
        second_cnt_q  <= second_cnt_d;
        last_first_q  <= last_first_d;
        last_second_q <= last_second_d;
      end
    end
  end

  assign done_o        = done_q;
  assign union_value_o = out_val_q;
  assign status_o      = out_sts_q;
  assign union_size_o  = out_size_q;

endmodule

### rtl/core/slu_checker.sv
module slu_checker
  import slu_pkg::*;
#(
  parameter int LIST_DEPTH = 16,
  localparam int CntW = $clog2(2 * LIST_DEPTH + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [2:0]         status_o,
  input logic [CntW-1:0]    union_size_o
);

  // An accepted transfer makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an input transfer");

  // A result never follows its own input transfer in the next cycle.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result strobe one cycle after input transfer");

  // Results are single-cycle strobes and appear only when idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy ##1 !done_o))
    else $error("result strobe while busy or held longer than a cycle");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StsCleared)) |-> (union_size_o == '0))
    else $error("union not empty after clear");

  a_added_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StsAdded)) |-> (union_size_o != '0))
    else $error("union empty after an item was added");

endmodule

bind sorted_list_union slu_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_slu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .union_size_o  (union_size_o)
);
